>>> hdl/cbpg_pkg.sv
// Shared types and constants for the color bar pattern generator.
// Holds the channel payload structs, the bar color tables and the bar edge coefficients.
// No dependencies.
package cbpg_pkg;

  localparam int unsigned CFG_W     = 13;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned POS_W     = 12;

  // Register indexes of the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(480);

  localparam int unsigned SEVEN_BARS  = 7;
  localparam int unsigned BOTTOM_BARS = 8;

  localparam logic [COLOR_W-1:0] BARS_BOTTOM [BOTTOM_BARS] = '{
    24'h001d42, 24'hebebeb, 24'h2c005c, 24'h101010,
    24'h070707, 24'h101010, 24'h181818, 24'h101010
  };
  localparam logic [COLOR_W-1:0] BARS_MIDDLE [SEVEN_BARS] = '{
    24'h0f0fb4, 24'h101010, 24'hb410b4, 24'h101010,
    24'h0db4b4, 24'h101010, 24'hb4b4b4
  };
  localparam logic [COLOR_W-1:0] BARS_TOP [SEVEN_BARS] = '{
    24'hb4b4b4, 24'hb4b40c, 24'h0db4b4, 24'h0db40c,
    24'hb410b4, 24'hb40f0e, 24'h0f0fb4
  };

  // Bar edge b lies at floor((w * K + C) / D). A column x is left of it when
  // (x + 1) * D <= w * K + C. Edges 0..5 split the seven-bar rows, edges
  // 6..12 split the bottom rows.
  localparam int unsigned NUM_BOUNDS  = 13;
  localparam int unsigned SEVEN_BASE  = 0;
  localparam int unsigned BOTTOM_BASE = 6;

  localparam int unsigned BOUND_K [NUM_BOUNDS] = '{
    1, 2, 3, 4, 5, 6, 5, 10, 15, 20, 16, 17, 18
  };
  localparam int unsigned BOUND_C [NUM_BOUNDS] = '{
    3, 3, 3, 3, 3, 3, 14, 14, 14, 14, 10, 10, 10
  };
  localparam int unsigned BOUND_D [NUM_BOUNDS] = '{
    7, 7, 7, 7, 7, 7, 28, 28, 28, 28, 21, 21, 21
  };

  typedef struct packed {
    logic restart;
  } cbpg_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [POS_W-1:0]   column_index;
    logic [POS_W-1:0]   row_index;
    logic               end_of_row;
    logic               end_of_frame;
  } cbpg_rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cbpg_cfg_t;

endpackage

>>> hdl/cbpg_chan_if.sv
// Valid/ready channel used for the pixel request, pixel result and configuration ports.
// The payload type is a parameter; no other dependencies.
interface cbpg_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

>>> hdl/color_bar_pattern_generator.sv
// Color bar pattern generator top level: config registers, raster counters, result register.
// Depends on cbpg_pkg, cbpg_chan_if and cbpg_bar_select.
//
//   channel   direction  payload                                          handshake
//   in_i      sink       restart                                          valid/ready
//   out_o     source     pixel_color, column_index, row_index, eor, eof   valid/ready
//   cfg_i     sink       index, data (frame_width = 0, frame_height = 1)   valid/ready
//
// One pixel per cycle while results are taken and no write settles: each accepted request's
// result is set by the edge compares and table select between counters and result register.
// A new request is taken while a result waits, as long as the result is taken the same cycle.
// In the cycle after reset and after each register write, in_i.ready is low while the
// bar edges derived from the frame size settle. cfg_i.ready is always high.
module color_bar_pattern_generator
  import cbpg_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbpg_chan_if.sink   in_i,
  cbpg_chan_if.source out_o,
  cbpg_chan_if.sink   cfg_i
);

  localparam int unsigned DW   = $clog2(MAX_DIM + 1);
  localparam int unsigned CW   = $clog2(MAX_DIM);
  localparam int unsigned NW   = DW + 5;
  localparam int unsigned CMPW = (DW > CFG_W) ? DW : CFG_W;

  logic [CFG_W-1:0] width_raw_q;
  logic [CFG_W-1:0] height_raw_q;
  logic             settle_q;

  logic [DW-1:0]    w_d, h_d;
  logic [DW-1:0]    w_q, h_q;
  logic [NW-1:0]    bound_q [NUM_BOUNDS];

  logic [CW-1:0]    col_q, row_q;
  logic [CW-1:0]    col_d, row_d;

  logic             out_valid_q;
  cbpg_rsp_t        out_q;

  logic             cfg_accept;
  logic             in_accept;
  logic [CW-1:0]    x, y;
  logic [DW-1:0]    x_nx, y_nx;
  logic             eor, eof;
  logic [COLOR_W-1:0] color;

  // Configuration registers
  assign cfg_i.ready = 1'b1;
  assign cfg_accept  = cfg_i.valid & cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_raw_q  <= FRAME_WIDTH_RST;
      height_raw_q <= FRAME_HEIGHT_RST;
      settle_q     <= 1'b1;
    end else begin
      settle_q <= cfg_accept;
      if (cfg_accept) begin
        if (cfg_i.data.index == REG_FRAME_WIDTH) begin
          width_raw_q <= cfg_i.data.data;
        end else if (cfg_i.data.index == REG_FRAME_HEIGHT) begin
          height_raw_q <= cfg_i.data.data;
        end
      end
    end
  end

  // Clamp the frame size to 1..MAX_DIM
  always_comb begin
    logic [CMPW-1:0] wr, hr;
    wr = CMPW'(width_raw_q);
    hr = CMPW'(height_raw_q);
    priority if (wr == '0) begin
      w_d = DW'(1);
    end else if (wr > CMPW'(MAX_DIM)) begin
      w_d = DW'(MAX_DIM);
    end else begin
      w_d = DW'(wr);
    end
    priority if (hr == '0) begin
      h_d = DW'(1);
    end else if (hr > CMPW'(MAX_DIM)) begin
      h_d = DW'(MAX_DIM);
    end else begin
      h_d = DW'(hr);
    end
  end

  // Derived frame size and bar edge numerators, refreshed every cycle
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    h_q <= h_d;
    for (int b = 0; b < NUM_BOUNDS; b++) begin
      bound_q[b] <= NW'(w_d) * NW'(BOUND_K[b]) + NW'(BOUND_C[b]);
    end
  end

  // Pixel position: restart or an out-of-frame counter starts over at zero
  assign in_i.ready = ~settle_q & (~out_valid_q | out_o.ready);
  assign in_accept  = in_i.valid & in_i.ready;

  always_comb begin
    x = (in_i.data.restart || (DW'(col_q) >= w_q)) ? '0 : col_q;
    y = (in_i.data.restart || (DW'(row_q) >= h_q)) ? '0 : row_q;
    x_nx = DW'(x) + DW'(1);
    y_nx = DW'(y) + DW'(1);
    eor  = (x_nx == w_q);
    eof  = eor & (y_nx == h_q);
    if (eor) begin
      col_d = '0;
      row_d = eof ? '0 : CW'(y_nx);
    end else begin
      col_d = CW'(x_nx);
      row_d = y;
    end
  end

  cbpg_bar_select #(
    .DW (DW),
    .CW (CW),
    .NW (NW)
  ) u_bar_select (
    .x_i     (x),
    .y_i     (y),
    .h_i     (h_q),
    .bound_i (bound_q),
    .color_o (color)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        col_q       <= col_d;
        row_q       <= row_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q.pixel_color  <= color;
      out_q.column_index <= POS_W'(x);
      out_q.row_index    <= POS_W'(y);
      out_q.end_of_row   <= eor;
      out_q.end_of_frame <= eof;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

>>> hdl/cbpg_bar_select.sv
// Bar color lookup for one pixel position: parallel edge compares and table select.
// Depends on cbpg_pkg for the color tables and edge coefficients.
module cbpg_bar_select
  import cbpg_pkg::*;
#(
  parameter int unsigned DW = 13,
  parameter int unsigned CW = 12,
  parameter int unsigned NW = 18
) (
  input  logic [CW-1:0]      x_i,
  input  logic [CW-1:0]      y_i,
  input  logic [DW-1:0]      h_i,
  input  logic [NW-1:0]      bound_i [NUM_BOUNDS],
  output logic [COLOR_W-1:0] color_o
);

  localparam int unsigned HW = DW + 2;

  logic [DW-1:0]         x1;
  logic [DW-1:0]         y1;
  logic [NUM_BOUNDS-1:0] hit;
  logic                  in_bottom;
  logic                  in_middle;

  assign x1 = DW'(x_i) + DW'(1);
  assign y1 = DW'(y_i) + DW'(1);

  for (genvar b = 0; b < NUM_BOUNDS; b++) begin : g_edge
    assign hit[b] = (NW'(x1) * NW'(BOUND_D[b])) <= bound_i[b];
  end

  // y < h/4 and y < h/3, the latter as 3 * (y + 1) <= h
  assign in_bottom = DW'(y_i) < (h_i >> 2);
  assign in_middle = (HW'(y1) * HW'(3)) <= HW'(h_i);

  always_comb begin
    logic [COLOR_W-1:0] c_top;
    logic [COLOR_W-1:0] c_mid;
    logic [COLOR_W-1:0] c_bot;
    c_top = BARS_TOP[SEVEN_BARS-1];
    c_mid = BARS_MIDDLE[SEVEN_BARS-1];
    for (int i = SEVEN_BARS - 2; i >= 0; i--) begin
      if (hit[SEVEN_BASE + i]) begin
        c_top = BARS_TOP[i];
        c_mid = BARS_MIDDLE[i];
      end
    end
    c_bot = BARS_BOTTOM[BOTTOM_BARS-1];
    for (int i = BOTTOM_BARS - 2; i >= 0; i--) begin
      if (hit[BOTTOM_BASE + i]) begin
        c_bot = BARS_BOTTOM[i];
      end
    end
    priority if (in_bottom) begin
      color_o = c_bot;
    end else if (in_middle) begin
      color_o = c_mid;
    end else begin
      color_o = c_top;
    end
  end

endmodule

>>> hdl/cbpg_checker.sv
// Port-level checks for the color bar pattern generator, bound to its top level.
// Depends on cbpg_pkg for the result payload type.
module cbpg_checker
  import cbpg_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      in_restart_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input cbpg_rsp_t out_data_i
);

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_i;

  // every accepted request shows a result at the next edge
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_i)
    else $error("accepted request produced no result");

  // restart puts the pixel at the frame origin
  a_restart_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_restart_i) |=>
      (out_data_i.column_index == '0 && out_data_i.row_index == '0))
    else $error("restart did not return to column 0 row 0");

  // end of frame only on the last pixel of a row
  a_eof_in_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.end_of_frame) |-> out_data_i.end_of_row)
    else $error("end_of_frame without end_of_row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed or dropped");

endmodule

bind color_bar_pattern_generator cbpg_checker u_cbpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_restart_i (in_i.data.restart),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_data_i   (out_o.data)
);

>>> sim/cbpg_pixel_checker.sv
// Pixel checker for the color bar pattern generator: watches the request, result and
// configuration channels, predicts every pixel and compares it field by field.
// Depends on cbpg_pkg and cbpg_chan_if.
module cbpg_pixel_checker
  import cbpg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  cbpg_chan_if.monitor     px_mon,
  cbpg_chan_if.monitor     out_mon,
  cbpg_chan_if.monitor     cfg_mon,
  output int unsigned      mismatch_count,
  output int unsigned      pending_count
);

  localparam int unsigned DIM_LIMIT = 4096;

  localparam logic [COLOR_W-1:0] LOW_COLORS [8] = '{
    24'h001d42, 24'hebebeb, 24'h2c005c, 24'h101010,
    24'h070707, 24'h101010, 24'h181818, 24'h101010
  };
  localparam logic [COLOR_W-1:0] MID_COLORS [7] = '{
    24'h0f0fb4, 24'h101010, 24'hb410b4, 24'h101010,
    24'h0db4b4, 24'h101010, 24'hb4b4b4
  };
  localparam logic [COLOR_W-1:0] HIGH_COLORS [7] = '{
    24'hb4b4b4, 24'hb4b40c, 24'h0db4b4, 24'h0db40c,
    24'hb410b4, 24'hb40f0e, 24'h0f0fb4
  };

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  int unsigned      next_col;
  int unsigned      next_row;
  cbpg_rsp_t        pixel_q [$];
  cbpg_rsp_t        want;
  cbpg_rsp_t        got;

  task automatic report_mismatch(input string msg);
    $display("%0t: pixel mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned frame_dim(input logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > DIM_LIMIT) return DIM_LIMIT;
    return raw;
  endfunction

  // Take the first bar whose right edge lies beyond the column.
  function automatic logic [COLOR_W-1:0] bar_color(input int unsigned x, input int unsigned y,
                                                   input int unsigned w, input int unsigned h);
    int unsigned bar;
    if (y < h / 4) begin
      bar = 7;
      for (int k = 6; k >= 4; k--) begin
        if (x < (w * (k + 12) + 10) / 21) bar = k;
      end
      for (int k = 3; k >= 0; k--) begin
        if (x < (w * (k + 1) * 5 + 14) / 28) bar = k;
      end
      return LOW_COLORS[bar];
    end
    bar = 6;
    for (int k = 5; k >= 0; k--) begin
      if (x < (w * (k + 1) + 3) / 7) bar = k;
    end
    return (y < h / 3) ? MID_COLORS[bar] : HIGH_COLORS[bar];
  endfunction

  function automatic cbpg_rsp_t predict_pixel(input logic restart);
    int unsigned w;
    int unsigned h;
    cbpg_rsp_t   px;
    w = frame_dim(width_reg);
    h = frame_dim(height_reg);
    if (restart) begin
      next_col = 0;
      next_row = 0;
    end
    // Wrap counters left outside a shrunken frame.
    if (next_col >= w) next_col = 0;
    if (next_row >= h) next_row = 0;
    px.pixel_color  = bar_color(next_col, next_row, w, h);
    px.column_index = POS_W'(next_col);
    px.row_index    = POS_W'(next_row);
    px.end_of_row   = (next_col + 1 == w);
    px.end_of_frame = px.end_of_row && (next_row + 1 == h);
    if (px.end_of_row) begin
      next_col = 0;
      next_row = px.end_of_frame ? 0 : next_row + 1;
    end else begin
      next_col = next_col + 1;
    end
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg      = FRAME_WIDTH_RST;
      height_reg     = FRAME_HEIGHT_RST;
      next_col       = 0;
      next_row       = 0;
      pixel_q.delete();
      mismatch_count = 0;
      pending_count  = 0;
    end else begin
      // Compare results before queuing this edge's request: a result never
      // belongs to the request accepted at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no request waiting", got));
        end else begin
          want = pixel_q.pop_front();
          if (got.pixel_color != want.pixel_color)
            report_mismatch($sformatf("pixel_color got %h want %h at col %0d row %0d",
                                      got.pixel_color, want.pixel_color,
                                      want.column_index, want.row_index));
          if (got.column_index != want.column_index)
            report_mismatch($sformatf("column_index got %0d want %0d",
                                      got.column_index, want.column_index));
          if (got.row_index != want.row_index)
            report_mismatch($sformatf("row_index got %0d want %0d",
                                      got.row_index, want.row_index));
          if (got.end_of_row != want.end_of_row)
            report_mismatch($sformatf("end_of_row got %b want %b at col %0d row %0d",
                                      got.end_of_row, want.end_of_row,
                                      want.column_index, want.row_index));
          if (got.end_of_frame != want.end_of_frame)
            report_mismatch($sformatf("end_of_frame got %b want %b at col %0d row %0d",
                                      got.end_of_frame, want.end_of_frame,
                                      want.column_index, want.row_index));
        end
      end
      if (px_mon.valid && px_mon.ready) pixel_q.push_back(predict_pixel(px_mon.data.restart));
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.data.index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_mon.data.data;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_mon.data.data;
          end
          default: begin
          end
        endcase
      end
      pending_count = pixel_q.size();
    end
  end

endmodule

>>> sim/color_bar_pattern_generator_tb.sv
// Testbench top for the color bar pattern generator: clock, reset, request and register
// stimulus, result stalls and the verdict. Checking lives in cbpg_pixel_checker.
// Depends on cbpg_pkg, cbpg_chan_if, cbpg_pixel_checker and the generator RTL.
module color_bar_pattern_generator_tb;
  import cbpg_pkg::*;

  localparam int unsigned DIM_LIMIT      = 4096;
  localparam int unsigned RANDOM_ITEMS   = 1650;
  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_FRAME_HEIGHT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned cur_w;
  int unsigned cur_h;

  cbpg_chan_if #(.T(cbpg_req_t)) px_req ();
  cbpg_chan_if #(.T(cbpg_rsp_t)) px_rsp ();
  cbpg_chan_if #(.T(cbpg_cfg_t)) cfg_wr ();

  always #5 clk_i = ~clk_i;

  color_bar_pattern_generator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (px_req),
    .out_o  (px_rsp),
    .cfg_i  (cfg_wr)
  );

  cbpg_pixel_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .px_mon         (px_req),
    .out_mon        (px_rsp),
    .cfg_mon        (cfg_wr),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  function automatic int unsigned frame_pixels(input int unsigned w, input int unsigned h);
    int unsigned ew;
    int unsigned eh;
    ew = (w == 0) ? 1 : ((w > DIM_LIMIT) ? DIM_LIMIT : w);
    eh = (h == 0) ? 1 : ((h > DIM_LIMIT) ? DIM_LIMIT : h);
    return ew * eh;
  endfunction

  // Mostly small frames so that whole frames pass; now and then an extreme.
  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CFG_W'(DIM_LIMIT);
      2:       return CFG_W'($urandom_range(DIM_LIMIT + 1, 8191));
      3:       return CFG_W'($urandom_range(0, 8191));
      4, 5, 6: return CFG_W'($urandom_range(17, 300));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after the write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr.valid      <= 1'b1;
    cfg_wr.data.index <= idx;
    cfg_wr.data.data  <= value;
    do @(posedge clk_i); while (!cfg_wr.ready);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic set_w, input logic [CFG_W-1:0] w,
                           input logic set_h, input logic [CFG_W-1:0] h,
                           input logic set_unused);
    if (set_unused)
      write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                CFG_W'($urandom_range(0, 8191)));
    if (set_w) begin
      write_reg(REG_FRAME_WIDTH, w);
      cur_w = w;
    end
    if (set_h) begin
      write_reg(REG_FRAME_HEIGHT, h);
      cur_h = h;
    end
    cfg_wr.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Call at a falling edge; returns at the falling edge after the request.
  task automatic send_pixel(input logic restart);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        px_req.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    px_req.valid        <= 1'b1;
    px_req.data.restart <= restart;
    do @(posedge clk_i); while (!px_req.ready);
    @(negedge clk_i);
  endtask

  // Drop the request and wait until every pixel has come back.
  task automatic drain();
    px_req.valid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
  endtask

  task automatic run_pixels(input int unsigned count, input int unsigned restart_odds);
    for (int unsigned i = 0; i < count; i++) begin
      send_pixel($urandom_range(0, restart_odds - 1) == 0);
    end
    drain();
  endtask

  // Result side: stall on a pattern of its own, with a long hold-off now and then
  // so that the block fills and stalls its request side.
  initial begin : rsp_stall
    int unsigned stretch_no;
    int unsigned span;
    int unsigned mode;
    stretch_no = 0;
    px_rsp.ready <= 1'b0;
    @(negedge clk_i);
    forever begin
      stretch_no++;
      if (stretch_no % 64 == 16) begin
        px_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 40);
        repeat (span) begin
          case (mode)
            0:       px_rsp.ready <= 1'b1;
            1:       px_rsp.ready <= 1'($urandom_range(0, 1));
            2:       px_rsp.ready <= ($urandom_range(0, 3) != 0);
            default: px_rsp.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (px_req.valid && px_req.ready) || (px_rsp.valid && px_rsp.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned total;
    int unsigned count;
    logic        set_w;
    logic        set_h;
    total               = 0;
    burst_left          = 0;
    quiet_cycles        = 0;
    cur_w               = FRAME_WIDTH_RST;
    cur_h               = FRAME_HEIGHT_RST;
    rst_ni              = 1'b0;
    px_req.valid        = 1'b0;
    px_req.data.restart = 1'b0;
    cfg_wr.valid        = 1'b0;
    cfg_wr.data         = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset sizes, with a restart mid-row.
    send_pixel(1'b0);
    send_pixel(1'b0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    drain();
    // Zero sizes act as one; the running column wraps.
    configure(1'b1, '0, 1'b1, '0, 1'b0);
    run_pixels(3, 1000);
    // Oversized registers saturate.
    configure(1'b1, '1, 1'b1, CFG_W'(DIM_LIMIT + 1), 1'b0);
    send_pixel(1'b0);
    send_pixel(1'b0);
    send_pixel(1'b1);
    drain();
    // Ignored index, then a full small frame covering bottom and top bands.
    write_reg(REG_LAST_UNUSED, '1);
    configure(1'b1, CFG_W'(3), 1'b1, CFG_W'(4), 1'b0);
    run_pixels(12, 1000);

    while (total < RANDOM_ITEMS) begin
      set_w = ($urandom_range(0, 3) != 0);
      set_h = ($urandom_range(0, 3) != 0);
      configure(set_w, pick_dim(), set_h, pick_dim(), $urandom_range(0, 7) == 0);
      count = frame_pixels(cur_w, cur_h);
      count = (count > 240) ? 240 : count + $urandom_range(1, count + 1);
      if (count > 240) count = 240;
      run_pixels(count, 40);
      total += count;
    end

    repeat (4) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/cbpg_pkg.sv
hdl/cbpg_chan_if.sv
hdl/cbpg_bar_select.sv
hdl/color_bar_pattern_generator.sv
hdl/cbpg_checker.sv
sim/cbpg_pixel_checker.sv
sim/color_bar_pattern_generator_tb.sv
